@@ sv/cltl_pkg.sv @@
`timescale 1ns / 1ps
package cltl_pkg;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       end_of_input;
	} in_t;

	typedef struct packed {
		logic [7:0] token_byte;
		logic       token_first;
		logic       token_last;
		logic       run_last;
	} out_t;

	typedef struct packed {
		logic [7:0] b;
		logic       first;
		logic       last;
	} tok_t;

	typedef struct packed {
		tok_t [3:0] tok;
		logic [2:0] cnt;
	} run_t;

	localparam logic [1:0] CM_NONE  = 2'd0;
	localparam logic [1:0] CM_LINE  = 2'd1;
	localparam logic [1:0] CM_BLOCK = 2'd2;
	localparam logic [1:0] CM_STAR  = 2'd3;

	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_LO    = 8'd33;
	localparam logic [7:0] CH_HI    = 8'd126;

endpackage

@@ sv/cltl_front.sv @@
`timescale 1ns / 1ps
module cltl_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  cltl_pkg::in_t  item,
	output cltl_pkg::run_t run
);

	typedef struct packed {
		logic       word_open;
		logic       word_suppressed;
		logic [7:0] held_word_byte;
		logic       word_emitted;
		logic [7:0] ho0;
		logic [7:0] ho1;
		logic [1:0] hcnt;
		logic       lkn;
		logic [1:0] cmode;
	} st_t;

	typedef struct packed {
		st_t            s;
		cltl_pkg::run_t r;
	} lx_t;

	st_t st_q;
	lx_t nx;

	function automatic logic is_punct(logic [7:0] c);
		case (c) inside
			"-", "/", "+", "*", "(", ")", "{", "}", "[", "]", "<", ">", "=", "&",
			"!", "?", "%", "^", ";", "\"", "'", "\\", ":", ",": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic can_hold(logic [7:0] c);
		case (c) inside
			"=", "!", "*", "+", "-", "/", "<", ">", "%", "^", "&", "|", "~": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic lx_t put(lx_t x, logic [7:0] b, logic f, logic l);
		if (x.r.cnt < 3'd4) begin
			x.r.tok[x.r.cnt[1:0]].b     = b;
			x.r.tok[x.r.cnt[1:0]].first = f;
			x.r.tok[x.r.cnt[1:0]].last  = l;
			x.r.cnt = x.r.cnt + 3'd1;
		end
		return x;
	endfunction

	function automatic lx_t flush_held(lx_t x);
		if (x.s.hcnt >= 2'd2) begin
			if (x.s.ho1 == cltl_pkg::CH_SLASH) begin
				x = put(x, x.s.ho0, 1'b1, 1'b1);
				x = put(x, cltl_pkg::CH_SLASH, 1'b1, 1'b1);
			end else begin
				x = put(x, x.s.ho0, 1'b1, 1'b0);
				x = put(x, x.s.ho1, 1'b0, 1'b1);
			end
		end else if (x.s.hcnt == 2'd1) begin
			x = put(x, x.s.ho0, 1'b1, 1'b1);
		end
		x.s.hcnt = 2'd0;
		return x;
	endfunction

	function automatic lx_t take_token(lx_t x, logic [7:0] t);
		logic [1:0] cnt;
		logic [7:0] hl;
		logic [7:0] a;
		cnt = (x.s.hcnt > 2'd2) ? 2'd2 : x.s.hcnt;
		hl = (cnt == 2'd2) ? x.s.ho1 : x.s.ho0;
		if (cnt != 2'd0 && hl == cltl_pkg::CH_SLASH &&
				(t == cltl_pkg::CH_SLASH || t == cltl_pkg::CH_STAR)) begin
			x.s.hcnt = cnt - 2'd1;
			x.s.cmode = (t == cltl_pkg::CH_SLASH) ? cltl_pkg::CM_LINE : cltl_pkg::CM_BLOCK;
			return x;
		end
		if (cnt == 2'd2 && x.s.ho1 == cltl_pkg::CH_SLASH) begin
			x = put(x, x.s.ho0, 1'b1, 1'b1);
			x.s.ho0 = cltl_pkg::CH_SLASH;
			cnt = 2'd1;
		end
		if (cnt == 2'd2) begin
			if (t == cltl_pkg::CH_EQ) begin
				x = put(x, x.s.ho0, 1'b1, 1'b0);
				x = put(x, x.s.ho1, 1'b0, 1'b0);
				x = put(x, cltl_pkg::CH_EQ, 1'b0, 1'b1);
				x.s.hcnt = 2'd0;
				return x;
			end
			x = put(x, x.s.ho0, 1'b1, 1'b0);
			x = put(x, x.s.ho1, 1'b0, 1'b1);
			cnt = 2'd0;
		end
		if (cnt == 2'd1) begin
			a = x.s.ho0;
			if (t == cltl_pkg::CH_SLASH) begin
				x.s.ho1 = cltl_pkg::CH_SLASH;
				x.s.hcnt = 2'd2;
				return x;
			end
			if (t == cltl_pkg::CH_EQ) begin
				x = put(x, a, 1'b1, 1'b0);
				x = put(x, cltl_pkg::CH_EQ, 1'b0, 1'b1);
				x.s.hcnt = 2'd0;
				return x;
			end
			if (t == a && (a == ">" || a == "<")) begin
				x.s.ho1 = a;
				x.s.hcnt = 2'd2;
				return x;
			end
			if (t == a && (a == "&" || a == "|" || a == "+" || a == "*" || a == "-")) begin
				x = put(x, a, 1'b1, 1'b0);
				x = put(x, a, 1'b0, 1'b1);
				x.s.hcnt = 2'd0;
				return x;
			end
			x = put(x, a, 1'b1, 1'b1);
		end
		x.s.hcnt = 2'd0;
		if (can_hold(t)) begin
			x.s.ho0 = t;
			x.s.hcnt = 2'd1;
		end else begin
			x = put(x, t, 1'b1, 1'b1);
		end
		return x;
	endfunction

	function automatic lx_t end_word(lx_t x);
		if (!x.s.word_open)
			return x;
		if (!x.s.word_suppressed) begin
			if (x.s.word_emitted)
				x = put(x, x.s.held_word_byte, 1'b0, 1'b1);
			else
				x = take_token(x, x.s.held_word_byte);
		end
		x.s.word_open = 1'b0;
		x.s.word_suppressed = 1'b0;
		x.s.word_emitted = 1'b0;
		x.s.held_word_byte = 8'd0;
		return x;
	endfunction

	function automatic lx_t word_byte(lx_t x, logic [7:0] c);
		if (!x.s.word_open) begin
			x.s.word_open = 1'b1;
			x.s.word_emitted = 1'b0;
			x.s.held_word_byte = 8'd0;
			if (c < cltl_pkg::CH_LO || c > cltl_pkg::CH_HI) begin
				x.s.word_suppressed = 1'b1;
			end else if (x.s.cmode != cltl_pkg::CM_NONE) begin
				if (x.s.cmode >= cltl_pkg::CM_BLOCK)
					x.s.cmode = cltl_pkg::CM_BLOCK;
				x.s.word_suppressed = 1'b1;
			end else begin
				x.s.word_suppressed = 1'b0;
				x.s.lkn = 1'b0;
				x.s.held_word_byte = c;
			end
			return x;
		end
		if (x.s.word_suppressed)
			return x;
		if (!x.s.word_emitted) begin
			x = flush_held(x);
			x = put(x, x.s.held_word_byte, 1'b1, 1'b0);
			x.s.word_emitted = 1'b1;
		end else begin
			x = put(x, x.s.held_word_byte, 1'b0, 1'b0);
		end
		x.s.held_word_byte = c;
		return x;
	endfunction

	always_comb begin
		logic [7:0] c;
		c = item.byte_in;
		nx = '0;
		nx.s = st_q;
		if (item.end_of_input) begin
			if (nx.s.cmode != cltl_pkg::CM_NONE)
				nx.s.word_suppressed = 1'b1;
			nx = end_word(nx);
			nx = flush_held(nx);
			nx.s = '0;
		end else if (c == cltl_pkg::CH_SP || c == cltl_pkg::CH_TAB) begin
			nx = end_word(nx);
		end else if (c == cltl_pkg::CH_NL) begin
			nx = end_word(nx);
			if (nx.s.cmode == cltl_pkg::CM_LINE) begin
				nx.s.cmode = cltl_pkg::CM_NONE;
				nx.s.lkn = 1'b1;
			end else if (nx.s.cmode >= cltl_pkg::CM_BLOCK) begin
				nx.s.cmode = cltl_pkg::CM_BLOCK;
			end else begin
				if (nx.s.hcnt != 2'd0) begin
					nx = flush_held(nx);
					nx.s.lkn = 1'b0;
				end
				if (!nx.s.lkn) begin
					nx = put(nx, cltl_pkg::CH_NL, 1'b1, 1'b1);
					nx.s.lkn = 1'b1;
				end
			end
		end else if (is_punct(c)) begin
			nx = end_word(nx);
			case (nx.s.cmode)
				cltl_pkg::CM_LINE: begin
				end
				cltl_pkg::CM_BLOCK: begin
					if (c == cltl_pkg::CH_STAR)
						nx.s.cmode = cltl_pkg::CM_STAR;
				end
				cltl_pkg::CM_STAR: begin
					if (c == cltl_pkg::CH_SLASH)
						nx.s.cmode = cltl_pkg::CM_NONE;
					else if (c != cltl_pkg::CH_STAR)
						nx.s.cmode = cltl_pkg::CM_BLOCK;
				end
				default: begin
					if (c != cltl_pkg::CH_SLASH)
						nx.s.lkn = 1'b0;
					nx = take_token(nx, c);
				end
			endcase
		end else begin
			nx = word_byte(nx, c);
		end
	end

	assign run = nx.r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= '0;
		else if (accept)
			st_q <= nx.s;
	end

endmodule

@@ sv/cltl_fifo.sv @@
`timescale 1ns / 1ps
module cltl_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  cltl_pkg::run_t wdata,
	output logic           full,
	input  logic           rd,
	output cltl_pkg::run_t rdata,
	output logic           empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cltl_pkg::run_t mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr && !full)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr && !full)
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			if (rd && !empty)
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			cnt_q <= cnt_q + CW'(wr && !full) - CW'(rd && !empty);
		end
	end

endmodule

@@ sv/cltl_back.sv @@
`timescale 1ns / 1ps
module cltl_back (
	input  logic           clk,
	input  logic           arst_n,
	input  cltl_pkg::run_t head,
	input  logic           head_empty,
	output logic           head_pop,
	input  logic           pop,
	output logic           empty,
	output cltl_pkg::out_t token
);

	logic [1:0] idx_q;
	logic       last;

	assign last  = ({1'b0, idx_q} == head.cnt - 3'd1);
	assign empty = head_empty;
	assign head_pop = pop && !head_empty && last;

	always_comb begin
		token.token_byte  = head.tok[idx_q].b;
		token.token_first = head.tok[idx_q].first;
		token.token_last  = head.tok[idx_q].last;
		token.run_last    = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (pop && !head_empty)
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
	end

endmodule

@@ sv/c_like_token_lexer.sv @@
`timescale 1ns / 1ps
// Result beats are registered: an accepted input beat's run is written to the run queue.
// Throughput: one input beat per cycle unless full; each input beat yields zero to four
// result beats, drained one per cycle while pop is high, through a run queue of DEPTH entries.
// Input stalls (full) only when the run queue holds DEPTH unfinished runs.
// Reset: arst_n clears lexer state and the queue at once; no clearing pass.
module c_like_token_lexer #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  cltl_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output cltl_pkg::out_t token
);

	cltl_pkg::run_t run, head;
	logic accept, head_empty, head_pop;

	assign accept = push && !full;

	cltl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.run    (run)
	);

	cltl_fifo #(.DEPTH(DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept && run.cnt != 3'd0),
		.wdata  (run),
		.full   (full),
		.rd     (head_pop),
		.rdata  (head),
		.empty  (head_empty)
	);

	cltl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.token      (token)
	);

endmodule

@@ sv/cltl_checker.sv @@
`timescale 1ns / 1ps
module cltl_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           push,
	input logic           full,
	input logic           empty,
	input logic           pop,
	input cltl_pkg::out_t token
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(token)))
		else $error("result beat changed while stalled");

	a_first_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && token.token_first) |->
		((token.token_byte >= cltl_pkg::CH_LO && token.token_byte <= cltl_pkg::CH_HI) ||
		 (token.token_byte == cltl_pkg::CH_NL && token.token_last)))
		else $error("token opens with a byte that should be dropped");

	a_newline_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && token.token_byte == cltl_pkg::CH_NL) |->
		(token.token_first && token.token_last))
		else $error("newline inside a longer token");

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({push, pop, full, empty}))
		else $error("handshake signal unknown");

endmodule

bind c_like_token_lexer cltl_checker u_chk (.*);

@@ dv/tb_c_like_token_lexer.sv @@
`timescale 1ns / 1ps
module tb_c_like_token_lexer;

	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_BAR   = 8'h7c;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	cltl_pkg::in_t  item;
	logic empty;
	logic pop;
	cltl_pkg::out_t token;

	c_like_token_lexer u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .token(token)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// lexer state
	logic       lx_word_open;
	logic       lx_word_supp;
	logic [7:0] lx_word_byte;
	logic       lx_word_sent;
	logic [7:0] lx_ops [2];
	int         lx_op_cnt;
	logic       lx_kept_nl;
	logic [1:0] lx_cmode;

	cltl_pkg::out_t step_toks [$];
	cltl_pkg::out_t token_fifo [$];
	int   errors;
	int   tokens_seen;
	int   beats_in;
	logic hold_off;
	logic quiet;

	function automatic logic is_punct(logic [7:0] c);
		case (c)
			"-", "/", "+", "*", "(", ")", "{", "}", "[", "]", "<", ">", "=", "&",
			"!", "?", "%", "^", ";", "\"", "'", "\\", ":", ",": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic can_hold(logic [7:0] c);
		case (c)
			"=", "!", "*", "+", "-", "/", "<", ">", "%", "^", "&", "|", "~": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic emit(logic [7:0] b, logic f, logic l);
		cltl_pkg::out_t t;
		t.token_byte  = b;
		t.token_first = f;
		t.token_last  = l;
		t.run_last    = 1'b0;
		if (step_toks.size() < 4) step_toks.push_back(t);
	endtask

	task automatic flush_ops();
		if (lx_op_cnt >= 2) begin
			if (lx_ops[1] == cltl_pkg::CH_SLASH) begin
				emit(lx_ops[0], 1, 1);
				emit(cltl_pkg::CH_SLASH, 1, 1);
			end else begin
				emit(lx_ops[0], 1, 0);
				emit(lx_ops[1], 0, 1);
			end
		end else if (lx_op_cnt == 1) begin
			emit(lx_ops[0], 1, 1);
		end
		lx_op_cnt = 0;
	endtask

	task automatic take_op(logic [7:0] t);
		int n;
		logic [7:0] a;
		n = lx_op_cnt > 2 ? 2 : lx_op_cnt;
		if (n >= 1 && lx_ops[n-1] == cltl_pkg::CH_SLASH &&
				(t == cltl_pkg::CH_SLASH || t == cltl_pkg::CH_STAR)) begin
			lx_op_cnt = n - 1;
			lx_cmode = (t == cltl_pkg::CH_SLASH) ? cltl_pkg::CM_LINE : cltl_pkg::CM_BLOCK;
			return;
		end
		if (n == 2 && lx_ops[1] == cltl_pkg::CH_SLASH) begin
			emit(lx_ops[0], 1, 1);
			lx_ops[0] = cltl_pkg::CH_SLASH;
			n = 1;
		end
		if (n == 2) begin
			if (t == cltl_pkg::CH_EQ) begin
				emit(lx_ops[0], 1, 0);
				emit(lx_ops[1], 0, 0);
				emit(cltl_pkg::CH_EQ, 0, 1);
				lx_op_cnt = 0;
				return;
			end
			emit(lx_ops[0], 1, 0);
			emit(lx_ops[1], 0, 1);
			n = 0;
		end
		if (n == 1) begin
			a = lx_ops[0];
			if (t == cltl_pkg::CH_SLASH) begin
				lx_ops[1] = cltl_pkg::CH_SLASH;
				lx_op_cnt = 2;
				return;
			end
			if (t == cltl_pkg::CH_EQ) begin
				emit(a, 1, 0);
				emit(cltl_pkg::CH_EQ, 0, 1);
				lx_op_cnt = 0;
				return;
			end
			if (t == a && (a == CH_GT || a == CH_LT)) begin
				lx_ops[1] = a;
				lx_op_cnt = 2;
				return;
			end
			if (t == a && (a == CH_AMP || a == CH_BAR || a == CH_PLUS ||
					a == cltl_pkg::CH_STAR || a == CH_MINUS)) begin
				emit(a, 1, 0);
				emit(a, 0, 1);
				lx_op_cnt = 0;
				return;
			end
			emit(a, 1, 1);
		end
		lx_op_cnt = 0;
		if (can_hold(t)) begin
			lx_ops[0] = t;
			lx_op_cnt = 1;
		end else begin
			emit(t, 1, 1);
		end
	endtask

	task automatic close_word();
		if (!lx_word_open) return;
		if (!lx_word_supp) begin
			if (lx_word_sent) emit(lx_word_byte, 0, 1);
			else take_op(lx_word_byte);
		end
		lx_word_open = 0;
		lx_word_supp = 0;
		lx_word_sent = 0;
		lx_word_byte = '0;
	endtask

	task automatic add_word_byte(logic [7:0] c);
		if (!lx_word_open) begin
			lx_word_open = 1;
			lx_word_sent = 0;
			lx_word_byte = '0;
			if (c < cltl_pkg::CH_LO || c > cltl_pkg::CH_HI) begin
				lx_word_supp = 1;
			end else if (lx_cmode != cltl_pkg::CM_NONE) begin
				if (lx_cmode >= cltl_pkg::CM_BLOCK) lx_cmode = cltl_pkg::CM_BLOCK;
				lx_word_supp = 1;
			end else begin
				lx_word_supp = 0;
				lx_kept_nl = 0;
				lx_word_byte = c;
			end
			return;
		end
		if (lx_word_supp) return;
		if (!lx_word_sent) begin
			flush_ops();
			emit(lx_word_byte, 1, 0);
			lx_word_sent = 1;
		end else begin
			emit(lx_word_byte, 0, 0);
		end
		lx_word_byte = c;
	endtask

	task automatic lexer_clear();
		lx_word_open = 0;
		lx_word_supp = 0;
		lx_word_byte = '0;
		lx_word_sent = 0;
		lx_ops[0] = '0;
		lx_ops[1] = '0;
		lx_op_cnt = 0;
		lx_kept_nl = 0;
		lx_cmode = cltl_pkg::CM_NONE;
	endtask

	task automatic lex_byte(cltl_pkg::in_t it);
		logic [7:0] c;
		c = it.byte_in;
		step_toks.delete();
		if (it.end_of_input) begin
			if (lx_cmode != cltl_pkg::CM_NONE) lx_word_supp = 1;
			close_word();
			flush_ops();
			lexer_clear();
		end else if (c == cltl_pkg::CH_SP || c == cltl_pkg::CH_TAB) begin
			close_word();
		end else if (c == cltl_pkg::CH_NL) begin
			close_word();
			if (lx_cmode == cltl_pkg::CM_LINE) begin
				lx_cmode = cltl_pkg::CM_NONE;
				lx_kept_nl = 1;
			end else if (lx_cmode >= cltl_pkg::CM_BLOCK) begin
				lx_cmode = cltl_pkg::CM_BLOCK;
			end else begin
				if (lx_op_cnt != 0) begin
					flush_ops();
					lx_kept_nl = 0;
				end
				if (!lx_kept_nl) begin
					emit(cltl_pkg::CH_NL, 1, 1);
					lx_kept_nl = 1;
				end
			end
		end else if (is_punct(c)) begin
			close_word();
			if (lx_cmode == cltl_pkg::CM_LINE) begin
			end else if (lx_cmode == cltl_pkg::CM_BLOCK) begin
				if (c == cltl_pkg::CH_STAR) lx_cmode = cltl_pkg::CM_STAR;
			end else if (lx_cmode == cltl_pkg::CM_STAR) begin
				if (c == cltl_pkg::CH_SLASH) lx_cmode = cltl_pkg::CM_NONE;
				else if (c != cltl_pkg::CH_STAR) lx_cmode = cltl_pkg::CM_BLOCK;
			end else begin
				if (c != cltl_pkg::CH_SLASH) lx_kept_nl = 0;
				take_op(c);
			end
		end else begin
			add_word_byte(c);
		end
		if (step_toks.size() > 0) step_toks[step_toks.size()-1].run_last = 1'b1;
		foreach (step_toks[i]) token_fifo.push_back(step_toks[i]);
	endtask

	task automatic send_beat(logic [7:0] b, logic eoi, logic idle_ok);
		cltl_pkg::in_t it;
		it.byte_in = b;
		it.end_of_input = eoi;
		while (idle_ok && !quiet && $urandom_range(99) < 19) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		lex_byte(it);
		beats_in++;
		@(negedge clk);
	endtask

	// directed row: byte, eoi, typed first result valid, byte/first/last/run_last expected
	typedef struct {
		logic [7:0]     b;
		logic           eoi;
		logic           typed;
		cltl_pkg::out_t want;
	} row_t;

	function automatic logic [7:0] pick_byte();
		int k;
		k = $urandom_range(99);
		if (k < 30) return 8'h61 + 8'($urandom_range(25));
		if (k < 55) begin
			case ($urandom_range(15))
				0: return "/"; 1: return "*"; 2: return "="; 3: return "<";
				4: return ">"; 5: return "&"; 6: return "|"; 7: return "+";
				8: return "-"; 9: return "!"; 10: return "~"; 11: return "%";
				12: return "^"; 13: return ";"; 14: return "("; default: return "\\";
			endcase
		end
		if (k < 70) return cltl_pkg::CH_SP;
		if (k < 80) return cltl_pkg::CH_NL;
		if (k < 84) return cltl_pkg::CH_TAB;
		return 8'($urandom_range(255));
	endfunction

	initial begin
		row_t rows [$];
		row_t r;
		string s;
		int limit;
		cltl_pkg::out_t got;
		errors = 0;
		tokens_seen = 0;
		beats_in = 0;
		quiet = 1'b0;
		push = 1'b0;
		item = '0;
		arst_n = 1'b0;
		lexer_clear();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		s = "a //c\n/*x*/==;";
		foreach (s[i]) begin
			r.b = s[i]; r.eoi = 0; r.typed = 0; r.want = '0;
			rows.push_back(r);
		end
		r.b = ";"; r.eoi = 0; r.typed = 1; r.want = '{";", 1, 1, 1};
		rows.push_back(r);
		s = ">>=<<=&&||++--**!= \t";
		foreach (s[i]) begin
			r.b = s[i]; r.eoi = 0; r.typed = 0; r.want = '0;
			rows.push_back(r);
		end
		r.b = 8'h00; r.eoi = 0; r.typed = 0; rows.push_back(r);
		r.b = 8'hff; r.eoi = 0; rows.push_back(r);
		r.b = "*"; rows.push_back(r);
		r.b = "/"; rows.push_back(r);
		r.b = "~"; r.eoi = 1; rows.push_back(r);
		r.b = "/"; r.eoi = 0; rows.push_back(r);
		r.b = "*"; rows.push_back(r);
		r.b = 8'h00; r.eoi = 1; rows.push_back(r);
		foreach (rows[i]) begin
			if (rows[i].typed) begin
				send_beat(rows[i].b, rows[i].eoi, 1'b0);
				got = '0;
				if (step_toks.size() != 0) got = step_toks[0];
				if (step_toks.size() == 0 || got !== rows[i].want) begin
					$display("%0t: directed row %0d expected %h actual prediction %h",
						$time, i, rows[i].want, got);
					errors++;
				end
			end else begin
				send_beat(rows[i].b, rows[i].eoi, 1'b1);
			end
		end
		push <= 1'b0;

		// sender pause until drained
		while (token_fifo.size() != 0) @(negedge clk);
		@(negedge clk);

		// long hold-off with a steady stream
		quiet = 1'b1;
		hold_off = 1'b1;
		for (int i = 0; i < 30; i++) send_beat(pick_byte(), 1'b0, 1'b1);
		quiet = 1'b0;

		for (int i = 0; i < 110; i++) begin
			if (i == 55) quiet = 1'b1;
			if (i == 80) quiet = 1'b0;
			send_beat(pick_byte(), $urandom_range(39) == 0, 1'b1);
		end
		send_beat(8'h00, 1'b1, 1'b1);
		push <= 1'b0;

		limit = 0;
		while (token_fifo.size() != 0 && limit < 10000) begin
			@(negedge clk);
			limit++;
		end
		if (token_fifo.size() != 0) begin
			$display("%0t: %0d expected tokens never arrived", $time, token_fifo.size());
			errors++;
		end
		repeat (10) @(negedge clk);
		$display("Sent %0d text beats, checked %0d token bytes, with stalls on both sides.",
			beats_in, tokens_seen);
		if (errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

	initial begin
		hold_off = 1'b0;
		wait (hold_off);
		repeat (60) @(negedge clk);
		hold_off = 1'b0;
	end

	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			pop <= !hold_off && (quiet || $urandom_range(99) >= 19);
		end
	end

	always @(posedge clk) begin
		cltl_pkg::out_t want;
		if (arst_n && pop && !empty) begin
			tokens_seen++;
			if (token_fifo.size() == 0) begin
				$display("%0t: unexpected token beat actual %h", $time, token);
				errors++;
			end else begin
				want = token_fifo.pop_front();
				if (token !== want) begin
					$display("%0t: token mismatch expected %h actual %h", $time, want, token);
					errors++;
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
